@@ design/tiny_register_machine_executor_unit_assert.svh @@
// Assertion macros shared by the register machine executor.
`ifndef TINY_REGISTER_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`define TINY_REGISTER_MACHINE_EXECUTOR_UNIT_ASSERT_SVH

// Checks that a property holds at every clock edge out of reset.
`define TRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define TRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/trm_pkg.sv @@
// Types, codes and constants of the register machine executor.
`default_nettype none

package trm_pkg;

    // Default number of architectural registers.
    localparam int NUM_REGS_DEF = 16;

    // Request kinds.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_EXEC  = 1'b1;

    // Instruction opcodes.
    typedef enum logic [7:0] {
        OP_RET  = 8'd0,
        OP_ADD  = 8'd1,
        OP_SUB  = 8'd2,
        OP_MOV  = 8'd3,
        OP_MOVI = 8'd4,
        OP_B    = 8'd5,
        OP_BNZ  = 8'd6
    } t_opcode;

    // Cycle costs that each instruction adds to the counter.
    localparam logic [31:0] CYC_RET  = 32'd1;
    localparam logic [31:0] CYC_ALU  = 32'd2;
    localparam logic [31:0] CYC_MOVI = 32'd6;

    // Instruction lengths in bytes.
    localparam logic [8:0] LEN_RET  = 9'd1;
    localparam logic [8:0] LEN_ALU  = 9'd2;
    localparam logic [8:0] LEN_MOVI = 9'd6;

    // One request item.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] param;
        logic [7:0]         opcode;
        logic [7:0]         operand_byte;
        logic signed [31:0] immediate;
    } t_req;

    // One result item.
    typedef struct packed {
        logic signed [8:0]  pc_delta;
        logic               done_res;
        logic signed [31:0] result_value;
        logic [31:0]        cycles_used;
        logic               illegal;
    } t_res;

    // Execute stage decisions handed from the ALU to the state update.
    typedef struct packed {
        logic        clear;
        logic        wr_en;
        logic [31:0] wr_data;
        logic        flag_en;
        logic        zero_n;
        logic        neg_n;
        logic [31:0] cycles_n;
        t_res        res;
    } t_exec;

endpackage

`default_nettype wire

@@ design/trm_stream_if.sv @@
// Valid/ready stream interfaces for requests and results.
`default_nettype none

interface trm_req_if;
    import trm_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trm_res_if;
    import trm_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/tiny_register_machine_executor_unit.sv @@
// Top level of the register machine executor: register RAM, execute stage, result register.
//
// The executor takes one request per clock cycle while the output is not stalled, and
// returns one result per request, in order. A request is transferred into the execute
// stage while the register RAM reads both operands; the next cycle the ALU works on the
// RAM data, and the result is loaded into the output register once it is free or drains.
// The single execute stage with its registered RAM read sets the rate of one request per
// cycle; a write in the execute stage is forwarded to the next request's operands. A start
// request clears the register file through per-register valid bits, with no clearing pass,
// and writes its parameter to register 0; a register whose valid bit is clear reads as
// zero. Indexes at or above NUM_REGS read zero and are never written.
`default_nettype none
`include "tiny_register_machine_executor_unit_assert.svh"

module tiny_register_machine_executor_unit #(
    parameter int NUM_REGS = trm_pkg::NUM_REGS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    trm_req_if.sink   i_req,
    trm_res_if.source o_res
);
    import trm_pkg::*;

    localparam int AW = $clog2(NUM_REGS);
    localparam logic [4:0] NREG = 5'(NUM_REGS);
    localparam logic [NUM_REGS-1:0] VLD_R0 = NUM_REGS'(1);

    // Execute stage and output registers.
    logic          r_s1_valid;
    t_req          r_s1;
    logic [3:0]    r_s1_anib;
    logic          r_out_valid;
    t_res          r_out;

    // Architectural state kept in flip-flops beside the RAM.
    logic [NUM_REGS-1:0] r_vld;
    logic                r_zero;
    logic                r_neg;
    logic [31:0]         r_cycles;

    // Most recent register write, for forwarding.
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [31:0]   r_fwd_data;

    logic          advance;
    logic          in_xfer;
    logic [3:0]    in_anib;
    logic [31:0]   ram_a;
    logic [31:0]   ram_b;
    logic [3:0]    s1_bnib;
    logic [3:0]    s1_dnib;
    logic          a_ok;
    logic          b_ok;
    logic          d_ok;
    logic [AW-1:0] a_idx;
    logic [AW-1:0] b_idx;
    logic [31:0]   opa;
    logic [31:0]   opb;
    t_exec         exec;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [NUM_REGS-1:0] n_vld;

    // Handshake: the execute stage moves on when the output register is free or drains.
    assign advance     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || advance;
    assign in_xfer     = i_req.valid && i_req.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // A return reads register 0 on port A; every other request reads its destination.
    assign in_anib = (i_req.data.opcode == OP_RET) ? 4'd0 : i_req.data.operand_byte[7:4];

    trm_ram #(
        .WIDTH (32),
        .DEPTH (NUM_REGS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (exec.wr_data),
        .i_re      (in_xfer),
        .i_raddr_a (in_anib[AW-1:0]),
        .i_raddr_b (i_req.data.operand_byte[AW-1:0]),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // Operand selection: range check, forwarding, then valid bit.
    assign s1_bnib = r_s1.operand_byte[3:0];
    assign s1_dnib = r_s1.operand_byte[7:4];
    assign a_ok    = {1'b0, r_s1_anib} < NREG;
    assign b_ok    = {1'b0, s1_bnib} < NREG;
    assign d_ok    = {1'b0, s1_dnib} < NREG;
    assign a_idx   = r_s1_anib[AW-1:0];
    assign b_idx   = s1_bnib[AW-1:0];

    always_comb begin
        if (!a_ok) begin
            opa = '0;
        end else if (r_fwd_valid && (r_fwd_addr == a_idx)) begin
            opa = r_fwd_data;
        end else if (r_vld[a_idx]) begin
            opa = ram_a;
        end else begin
            opa = '0;
        end
        if (!b_ok) begin
            opb = '0;
        end else if (r_fwd_valid && (r_fwd_addr == b_idx)) begin
            opb = r_fwd_data;
        end else if (r_vld[b_idx]) begin
            opb = ram_b;
        end else begin
            opb = '0;
        end
    end

    trm_alu u_alu (
        .i_req    (r_s1),
        .i_opa    (opa),
        .i_opb    (opb),
        .i_zero   (r_zero),
        .i_cycles (r_cycles),
        .o_exec   (exec)
    );

    // Write back: a start writes register 0, other writes go to an in-range destination.
    assign ram_waddr = exec.clear ? '0 : s1_dnib[AW-1:0];
    assign ram_we    = advance && exec.wr_en && (exec.clear || d_ok);

    always_comb begin
        n_vld = r_vld;
        if (advance && exec.clear) begin
            n_vld = VLD_R0;
        end else if (ram_we) begin
            n_vld[ram_waddr] = 1'b1;
        end
    end

    // Control state, flags and counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_zero      <= 1'b0;
            r_neg       <= 1'b0;
            r_cycles    <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            r_vld <= n_vld;
            if (advance) begin
                r_cycles <= exec.cycles_n;
                if (exec.flag_en) begin
                    r_zero <= exec.zero_n;
                    r_neg  <= exec.neg_n;
                end
            end
            if (ram_we) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1      <= i_req.data;
            r_s1_anib <= in_anib;
        end
        if (advance) begin
            r_out <= exec.res;
        end
        if (ram_we) begin
            r_fwd_addr <= ram_waddr;
            r_fwd_data <= exec.wr_data;
        end
    end

    // Assertions.
    `TRM_ASSERT_NEXT(a_start_clears, advance && exec.clear, (r_vld == VLD_R0) && (r_cycles == 32'd0), "start did not leave only register 0 valid with a cleared counter")
    `TRM_ASSERT_NEXT(a_illegal_keeps, advance && exec.res.illegal, $stable(r_cycles) && $stable(r_vld), "illegal opcode changed state")
    `TRM_ASSERT_NEXT(a_write_valid, ram_we, r_fwd_valid && r_vld[r_fwd_addr], "written register not marked valid")
    `TRM_ASSERT_ALWAYS(a_ready_free, !r_out_valid |-> i_req.ready, "request stalled with a free output register")

endmodule

`default_nettype wire

@@ design/trm_ram.sv @@
// Generic synchronous RAM: one write port, two registered read ports.
`default_nettype none

module trm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports return the contents before a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ design/trm_alu.sv @@
// Instruction decode and execute for one request.
`default_nettype none

module trm_alu (
    input  wire trm_pkg::t_req  i_req,
    input  wire logic [31:0]    i_opa,
    input  wire logic [31:0]    i_opb,
    input  wire logic           i_zero,
    input  wire logic [31:0]    i_cycles,
    output trm_pkg::t_exec      o_exec
);
    import trm_pkg::*;

    logic [31:0] sum;
    logic [31:0] diff;
    logic [8:0]  branch_delta;

    assign sum          = i_opa + i_opb;
    assign diff         = i_opa - i_opb;
    assign branch_delta = LEN_ALU + {i_req.operand_byte[7], i_req.operand_byte};

    // Decode the request and form the state update and the result.
    always_comb begin
        o_exec                  = '0;
        o_exec.cycles_n         = i_cycles;
        o_exec.res.cycles_used  = i_cycles;
        if (i_req.req_type == REQ_START) begin
            o_exec.clear    = 1'b1;
            o_exec.wr_en    = 1'b1;
            o_exec.wr_data  = i_req.param;
            o_exec.flag_en  = 1'b1;
            o_exec.cycles_n = '0;
            o_exec.res.cycles_used = '0;
        end else begin
            case (i_req.opcode)
                OP_RET: begin
                    o_exec.cycles_n         = i_cycles + CYC_RET;
                    o_exec.res.pc_delta     = LEN_RET;
                    o_exec.res.done_res     = 1'b1;
                    o_exec.res.result_value = i_opa;
                end
                OP_ADD: begin
                    o_exec.wr_en    = 1'b1;
                    o_exec.wr_data  = sum;
                    o_exec.flag_en  = 1'b1;
                    o_exec.zero_n   = (sum == 32'd0);
                    o_exec.neg_n    = sum[31];
                    o_exec.cycles_n = i_cycles + CYC_ALU;
                    o_exec.res.pc_delta = LEN_ALU;
                end
                OP_SUB: begin
                    o_exec.wr_en    = 1'b1;
                    o_exec.wr_data  = diff;
                    o_exec.flag_en  = 1'b1;
                    o_exec.zero_n   = (diff == 32'd0);
                    o_exec.neg_n    = diff[31];
                    o_exec.cycles_n = i_cycles + CYC_ALU;
                    o_exec.res.pc_delta = LEN_ALU;
                end
                OP_MOV: begin
                    o_exec.wr_en    = 1'b1;
                    o_exec.wr_data  = i_opb;
                    o_exec.cycles_n = i_cycles + CYC_ALU;
                    o_exec.res.pc_delta = LEN_ALU;
                end
                OP_MOVI: begin
                    o_exec.wr_en    = 1'b1;
                    o_exec.wr_data  = i_req.immediate;
                    o_exec.cycles_n = i_cycles + CYC_MOVI;
                    o_exec.res.pc_delta = LEN_MOVI;
                end
                OP_B: begin
                    o_exec.cycles_n     = i_cycles + CYC_ALU;
                    o_exec.res.pc_delta = branch_delta;
                end
                OP_BNZ: begin
                    o_exec.cycles_n     = i_cycles + CYC_ALU;
                    o_exec.res.pc_delta = i_zero ? LEN_ALU : branch_delta;
                end
                default: begin
                    o_exec.res.illegal = 1'b1;
                end
            endcase
            o_exec.res.cycles_used = o_exec.cycles_n;
        end
    end

endmodule

`default_nettype wire
